FILE: hdl/assert_macros.svh
// Assertion macros shared by the interleaver modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define CVI_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// The expression must never be true at a clock edge outside reset.
`define CVI_NEVER(name, expr, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error(msg);

`endif

FILE: hdl/cvi_pkg.sv
// Types, constants and helper functions of the convolutional interleaver.
`timescale 1ns / 1ps
`default_nettype none
package cvi_pkg;

    localparam int DEF_MAX_BRANCHES = 16;
    localparam int DEF_MAX_DELAY    = 32;
    localparam int QUEUE_DEPTH      = 4;
    localparam int OUT_DEPTH        = 8;
    localparam int CFG_INDEX_W      = 2;
    localparam int CFG_DATA_W       = 6;
    localparam int BRANCH_OUT_W     = 4;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_BRANCH_COUNT = 2'd0,
        REG_CELL_DELAY   = 2'd1,
        REG_DIRECTION    = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [7:0] symbol_in;
        logic       block_start;
    } t_in;

    typedef struct packed {
        logic [7:0]              symbol_out;
        logic [BRANCH_OUT_W-1:0] branch_out;
    } t_out;

    // Raw register values plus a one-cycle strobe that empties all lines.
    typedef struct packed {
        logic [4:0] branch_count;
        logic [5:0] cell_delay;
        logic       direction;
        logic       clear;
    } t_cfg;

    // Zero counts as one, values above the limit saturate at the limit.
    function automatic int unsigned sat_value(input logic [5:0] raw,
                                              input int unsigned limit);
        int unsigned v;
        v = {26'd0, raw};
        if (v == 0) begin
            v = 1;
        end else if (v > limit) begin
            v = limit;
        end
        return v;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/cvi_fifo.sv
// Small synchronous FIFO used for the request queue and the output buffer.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module cvi_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_data,
    output logic                       o_empty,
    output logic                       o_full,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    import cvi_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_count;
    logic [PW-1:0]    n_wr;
    logic [PW-1:0]    n_rd;

    assign n_wr    = (r_wr == PW'(DEPTH-1)) ? '0 : r_wr + PW'(1);
    assign n_rd    = (r_rd == PW'(DEPTH-1)) ? '0 : r_rd + PW'(1);
    assign o_data  = r_mem[r_rd];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    `CVI_NEVER(a_fifo_overflow, i_push && o_full, "push into a full FIFO")
    `CVI_NEVER(a_fifo_underflow, i_pop && o_empty, "pop from an empty FIFO")

endmodule
`default_nettype wire

FILE: hdl/cvi_front.sv
// Front end: accepts requests and assigns each one its commutator branch.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module cvi_front #(
    parameter int MAX_BRANCHES = cvi_pkg::DEF_MAX_BRANCHES
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  cvi_pkg::t_cfg                   i_cfg,
    input  logic                            i_valid,
    input  logic                            i_full,
    input  cvi_pkg::t_in                    i_item,
    output logic                            o_stall,
    output logic                            o_push,
    output logic [$clog2(MAX_BRANCHES)-1:0] o_branch,
    output logic [$clog2(MAX_BRANCHES)-1:0] o_k
);
    import cvi_pkg::*;

    localparam int BW  = $clog2(MAX_BRANCHES);
    localparam int NBW = $clog2(MAX_BRANCHES+1);

    logic [BW-1:0]  r_branch;
    logic [BW-1:0]  n_branch;
    logic [NBW-1:0] w_nb;
    logic [BW-1:0]  w_cur;
    logic           w_last;

    assign w_nb  = NBW'(sat_value({1'b0, i_cfg.branch_count}, MAX_BRANCHES));

    // A block start restarts at branch zero; a stale position past the
    // branch count wraps as well.
    assign w_cur = (i_item.block_start || (NBW'(r_branch) >= w_nb)) ? '0 : r_branch;
    assign w_last   = (NBW'(w_cur) + NBW'(1)) >= w_nb;
    assign n_branch = w_last ? '0 : w_cur + BW'(1);

    assign o_stall  = i_full;
    assign o_push   = i_valid && !i_full;
    assign o_branch = w_cur;
    assign o_k      = i_cfg.direction ? BW'(w_nb - NBW'(1) - NBW'(w_cur)) : w_cur;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg.clear) begin
            r_branch <= '0;
        end else if (o_push) begin
            r_branch <= n_branch;
        end
    end

    `CVI_ASSERT(a_branch_range, o_push |-> (NBW'(o_branch) < w_nb),
        "branch index beyond branch count")

endmodule
`default_nettype wire

FILE: hdl/cvi_back.sv
// Back end: delay line addressing, line storage and result forming.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module cvi_back #(
    parameter int MAX_BRANCHES = cvi_pkg::DEF_MAX_BRANCHES,
    parameter int MAX_DELAY    = cvi_pkg::DEF_MAX_DELAY
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  cvi_pkg::t_cfg                           i_cfg,
    input  logic                                    i_task_valid,
    input  cvi_pkg::t_in                            i_task_item,
    input  logic [$clog2(MAX_BRANCHES)-1:0]         i_task_branch,
    input  logic [$clog2(MAX_BRANCHES)-1:0]         i_task_k,
    output logic                                    o_task_pop,
    input  logic [$clog2(cvi_pkg::OUT_DEPTH+1)-1:0] i_out_count,
    output logic                                    o_out_push,
    output cvi_pkg::t_out                           o_out_item
);
    import cvi_pkg::*;

    localparam int BW = $clog2(MAX_BRANCHES);
    localparam int DW = $clog2(MAX_DELAY+1);
    localparam int HW = $clog2((MAX_BRANCHES-1)*MAX_DELAY+1);
    localparam int TW = $clog2(MAX_BRANCHES*(MAX_BRANCHES-1)/2+1);
    localparam int SS = MAX_DELAY*MAX_BRANCHES*(MAX_BRANCHES-1)/2;
    localparam int AW = (SS > 1) ? $clog2(SS) : 1;
    localparam int CW = $clog2(OUT_DEPTH+1);

    logic [DW-1:0]      w_d;
    logic [CW-1:0]      w_busy;
    logic [2*BW-1:0]    w_kk;
    logic [BW+DW-1:0]   w_kd;
    logic [TW+DW-1:0]   w_base_full;

    // Stage A: triangular offset and line depth.
    logic               r_va;
    logic [7:0]         r_a_sym;
    logic               r_a_start;
    logic [BW-1:0]      r_a_branch;
    logic [TW-1:0]      r_a_tri;
    logic [HW-1:0]      r_a_depth;

    // Stage B: line base address; line access happens here.
    logic               r_vb;
    logic [7:0]         r_b_sym;
    logic               r_b_start;
    logic [BW-1:0]      r_b_branch;
    logic [AW-1:0]      r_b_base;
    logic [HW-1:0]      r_b_depth;

    // Stage D: side data next to the registered read.
    logic               r_vd;
    logic [7:0]         r_d_sym;
    logic [BW-1:0]      r_d_branch;
    logic               r_d_zero;
    logic               r_d_filled;
    logic [7:0]         r_rd;

    logic [HW-1:0]      r_head [MAX_BRANCHES];
    logic [HW-1:0]      r_fill [MAX_BRANCHES];
    logic [7:0]         r_mem  [SS];

    logic               w_clr;
    logic [HW-1:0]      w_hraw;
    logic [HW-1:0]      w_head;
    logic [HW-1:0]      w_fill;
    logic               w_zero;
    logic               w_filled;
    logic [AW-1:0]      w_pos;
    logic [HW-1:0]      n_head;
    logic [HW-1:0]      n_fill;

    assign w_d = DW'(sat_value(i_cfg.cell_delay, MAX_DELAY));

    // Every item in flight has a reserved place in the output buffer.
    assign w_busy     = CW'(r_va) + CW'(r_vb) + CW'(r_vd) + i_out_count;
    assign o_task_pop = i_task_valid && (w_busy < CW'(OUT_DEPTH));

    assign w_kk = {{BW{1'b0}}, i_task_k} * {{BW{1'b0}}, i_task_k - BW'(1)};
    assign w_kd = {{DW{1'b0}}, i_task_k} * {{BW{1'b0}}, w_d};
    assign w_base_full = {{DW{1'b0}}, r_a_tri} * {{TW{1'b0}}, w_d};

    // Line access for the item in stage B. A block start in deinterleave
    // mode empties every line before this item is served.
    assign w_clr    = r_b_start && i_cfg.direction;
    assign w_hraw   = r_head[r_b_branch];
    assign w_head   = (w_clr || (w_hraw >= r_b_depth)) ? '0 : w_hraw;
    assign w_fill   = w_clr ? '0 : r_fill[r_b_branch];
    assign w_zero   = (r_b_depth == '0);
    assign w_filled = (w_fill >= r_b_depth);
    assign w_pos    = r_b_base + AW'(w_head);
    assign n_head   = ((w_head + HW'(1)) == r_b_depth) ? '0 : w_head + HW'(1);
    assign n_fill   = w_filled ? w_fill : w_fill + HW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vd <= 1'b0;
        end else begin
            r_va <= o_task_pop;
            r_vb <= r_va;
            r_vd <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_sym    <= i_task_item.symbol_in;
        r_a_start  <= i_task_item.block_start;
        r_a_branch <= i_task_branch;
        r_a_tri    <= TW'(w_kk >> 1);
        r_a_depth  <= HW'(w_kd);

        r_b_sym    <= r_a_sym;
        r_b_start  <= r_a_start;
        r_b_branch <= r_a_branch;
        r_b_base   <= AW'(w_base_full);
        r_b_depth  <= r_a_depth;

        r_d_sym    <= r_b_sym;
        r_d_branch <= r_b_branch;
        r_d_zero   <= w_zero;
        r_d_filled <= w_filled;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg.clear) begin
            for (int i = 0; i < MAX_BRANCHES; i++) begin
                r_head[i] <= '0;
                r_fill[i] <= '0;
            end
        end else if (r_vb) begin
            if (w_clr) begin
                for (int i = 0; i < MAX_BRANCHES; i++) begin
                    r_head[i] <= '0;
                    r_fill[i] <= '0;
                end
            end
            if (!w_zero) begin
                r_head[r_b_branch] <= n_head;
                r_fill[r_b_branch] <= n_fill;
            end
        end
    end

    // Read returns the byte stored before this write.
    always_ff @(posedge i_clk) begin
        if (r_vb && !w_zero) begin
            r_mem[w_pos] <= r_b_sym;
        end
        r_rd <= r_mem[w_pos];
    end

    // Entries not yet written since the last clear read as zero.
    assign o_out_push            = r_vd;
    assign o_out_item.symbol_out = r_d_zero ? r_d_sym : (r_d_filled ? r_rd : 8'h00);
    assign o_out_item.branch_out = BRANCH_OUT_W'(r_d_branch);

    `CVI_ASSERT(a_pos_range, (r_vb && !w_zero) |-> ({1'b0, w_pos} < (AW+1)'(SS)),
        "line address beyond storage")
    `CVI_ASSERT(a_out_credit, r_vd |-> (i_out_count < CW'(OUT_DEPTH)),
        "result arrives with no room reserved in the output buffer")

endmodule
`default_nettype wire

FILE: hdl/convolutional_interleaver.sv
// Top level of the convolutional interleaver and deinterleaver.
//
//  Port group   Direction  Handshake                Payload
//  i_in_*       in         i_in_valid / o_in_stall   i_in_item (symbol_in, block_start)
//  o_out_*      out        o_out_valid / i_out_stall o_out_item (symbol_out, branch_out)
//  i_cfg_*      in         i_cfg_we                  i_cfg_index, i_cfg_data
//
// Sustains one request per clock while i_out_stall stays low; the line store
// has one read and one write per cycle, and each request uses one of each.
// A request passes the request queue, two address stages, the registered line
// read and the output buffer before it reaches o_out_valid.
// Reset needs no clearing pass: per-branch fill counts make unwritten line
// entries read as zero, so requests are accepted right after reset.
// o_in_stall rises only when the request queue is full; the back end holds
// off when the output buffer has no room for what is already in flight.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module convolutional_interleaver #(
    parameter int MAX_BRANCHES = cvi_pkg::DEF_MAX_BRANCHES,
    parameter int MAX_DELAY    = cvi_pkg::DEF_MAX_DELAY
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  cvi_pkg::t_in                    i_in_item,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output cvi_pkg::t_out                   o_out_item,
    input  logic                            i_cfg_we,
    input  logic [cvi_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [cvi_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import cvi_pkg::*;

    localparam int BW   = $clog2(MAX_BRANCHES);
    localparam int IN_W = $bits(t_in);
    localparam int QW   = IN_W + 2*BW;
    localparam int OW   = $bits(t_out);
    localparam int QCW  = $clog2(QUEUE_DEPTH+1);
    localparam int OCW  = $clog2(OUT_DEPTH+1);

    logic [4:0]     r_branch_count;
    logic [5:0]     r_cell_delay;
    logic           r_direction;
    logic           w_cfg_hit;
    t_cfg           w_cfg;

    logic           w_push;
    logic           w_q_full;
    logic           w_q_empty;
    logic [QCW-1:0] w_q_count;
    logic [BW-1:0]  w_f_branch;
    logic [BW-1:0]  w_f_k;
    logic [QW-1:0]  w_q_wdata;
    logic [QW-1:0]  w_q_rdata;
    t_in            w_task_item;
    logic [BW-1:0]  w_task_branch;
    logic [BW-1:0]  w_task_k;
    logic           w_task_pop;

    logic           w_out_push;
    t_out           w_out_item;
    logic [OW-1:0]  w_out_rdata;
    logic           w_out_empty;
    logic           w_out_full;
    logic [OCW-1:0] w_out_count;
    logic           w_out_pop;

    always_comb begin
        unique case (t_reg_idx'(i_cfg_index))
            REG_BRANCH_COUNT,
            REG_CELL_DELAY,
            REG_DIRECTION:    w_cfg_hit = i_cfg_we;
            default:          w_cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_branch_count <= 5'd1;
            r_cell_delay   <= 6'd1;
            r_direction    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_BRANCH_COUNT: r_branch_count <= i_cfg_data[4:0];
                REG_CELL_DELAY:   r_cell_delay   <= i_cfg_data[5:0];
                REG_DIRECTION:    r_direction    <= i_cfg_data[0];
                default:          ;
            endcase
        end
    end

    // Any valid register write empties every line and restarts the commutator.
    assign w_cfg.branch_count = r_branch_count;
    assign w_cfg.cell_delay   = r_cell_delay;
    assign w_cfg.direction    = r_direction;
    assign w_cfg.clear        = w_cfg_hit;

    cvi_front #(
        .MAX_BRANCHES (MAX_BRANCHES)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_valid  (i_in_valid),
        .i_full   (w_q_full),
        .i_item   (i_in_item),
        .o_stall  (o_in_stall),
        .o_push   (w_push),
        .o_branch (w_f_branch),
        .o_k      (w_f_k)
    );

    assign w_q_wdata = {i_in_item, w_f_branch, w_f_k};

    cvi_fifo #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_q_wdata),
        .i_pop   (w_task_pop),
        .o_data  (w_q_rdata),
        .o_empty (w_q_empty),
        .o_full  (w_q_full),
        .o_count (w_q_count)
    );

    assign w_task_item   = w_q_rdata[QW-1 -: IN_W];
    assign w_task_branch = w_q_rdata[2*BW-1 -: BW];
    assign w_task_k      = w_q_rdata[BW-1:0];

    cvi_back #(
        .MAX_BRANCHES (MAX_BRANCHES),
        .MAX_DELAY    (MAX_DELAY)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_task_valid  (!w_q_empty),
        .i_task_item   (w_task_item),
        .i_task_branch (w_task_branch),
        .i_task_k      (w_task_k),
        .o_task_pop    (w_task_pop),
        .i_out_count   (w_out_count),
        .o_out_push    (w_out_push),
        .o_out_item    (w_out_item)
    );

    assign w_out_pop = !w_out_empty && !i_out_stall;

    cvi_fifo #(
        .WIDTH (OW),
        .DEPTH (OUT_DEPTH)
    ) u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_out_push),
        .i_data  (w_out_item),
        .i_pop   (w_out_pop),
        .o_data  (w_out_rdata),
        .o_empty (w_out_empty),
        .o_full  (w_out_full),
        .o_count (w_out_count)
    );

    assign o_out_valid = !w_out_empty;
    assign o_out_item  = w_out_rdata;

    `CVI_NEVER(a_full_flags, (w_q_full != (w_q_count == QCW'(QUEUE_DEPTH))) ||
        (w_out_full != (w_out_count == OCW'(OUT_DEPTH))),
        "full flag disagrees with the fill count")

endmodule
`default_nettype wire
